// ===== hdl/pafc_pkg.sv =====
// Shared types and constants for the phase-angle firing controller.
package pafc_pkg;

  localparam int unsigned PAddrW = 4;
  localparam int unsigned PDataW = 32;

  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegHalfPeriod = 2'd1;
  localparam logic [1:0] RegPulse = 2'd2;

  localparam logic [9:0] DebounceReset = 10'd250;
  localparam logic [7:0] HalfPeriodReset = 8'd10;
  localparam logic [4:0] PulseReset = 5'd1;

  localparam logic [9:0] ElapsedMax = 10'd1023;
  localparam logic [3:0] LetterL = 4'd10;
  localparam int unsigned DigitStep = 410;
  localparam int unsigned DigitCount = 9;

  localparam logic [6:0] SegTable [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h38, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic [9:0] debounce_ticks;
    logic [7:0] half_period_ticks;
    logic [4:0] pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic        button_pressed;
    logic [11:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic       grid_level;
    logic       fire_pulse;
    logic [6:0] segments;
    logic       armed_flag;
  } out_t;

endpackage

// ===== hdl/phase_angle_firing_controller_core.sv =====
// Top level of the phase-angle firing controller with its tick pipeline.
//
// Each input transaction is one millisecond tick carrying the button level
// and a 12-bit potentiometer sample; each tick yields exactly one result
// transaction with the grid level, firing pulse, display segments and the
// armed flag. Both channels use valid and stall.
// An accepted tick sits in the input register and is processed once the result
// register is free, and its result is then held in the result register.
// One tick is accepted every cycle while the receiver does not stall; the
// state update (arm flag, phase counter, latched delay) sets this rate.
// While the receiver stalls, the result holds and one further tick may be
// taken into the input register before the input side stalls in turn.
// Reset clears the pipeline, leaves the block locked with phase zero and
// the display showing L, and restores the default configuration.
// Configuration is written through the APB port; the user must write it only while no tick is in flight (not enforced).
module phase_angle_firing_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pafc_pkg::PAddrW-1:0]  paddr,
  input  logic [pafc_pkg::PDataW-1:0]  pwdata,
  output logic [pafc_pkg::PDataW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pafc_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pafc_pkg::out_t               out_data_o
);
  import pafc_pkg::*;

  cfg_t       cfg;
  in_t        stage_q;
  logic       stage_valid_q;
  out_t       out_q;
  out_t       out_d;
  logic       out_valid_q;
  logic       out_free;
  logic       step;
  logic       accept;

  logic       armed_q, armed_d;
  logic [9:0] since_q, since_d;
  logic [8:0] phase_q, phase_d;
  logic [7:0] delay_q, delay_d;
  logic [3:0] digit_q, digit_d;

  logic [7:0] calc_delay;
  logic [3:0] calc_digit;
  logic [9:0] since_inc;
  logic       phase_zero;
  logic       toggle;
  logic [7:0] eff_delay;
  logic [9:0] phase_inc;
  logic [9:0] fire_end;
  logic       grid;
  logic       fire;

  pafc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pafc_calc u_calc (
    .sample_i (stage_q.adc_sample),
    .half_i   (cfg.half_period_ticks),
    .width_i  (cfg.pulse_ticks),
    .delay_o  (calc_delay),
    .digit_o  (calc_digit)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign step        = stage_valid_q && out_free;
  assign in_stall_o  = stage_valid_q && !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    since_inc  = (since_q == ElapsedMax) ? since_q : since_q + 10'd1;
    phase_zero = (phase_q == 9'd0);
    toggle     = phase_zero && stage_q.button_pressed &&
                 (since_inc > cfg.debounce_ticks);
    armed_d    = armed_q ^ toggle;
    since_d    = toggle ? 10'd0 : since_inc;
    eff_delay  = phase_zero ? calc_delay : delay_q;
    phase_inc  = {1'b0, phase_q} + 10'd1;
    fire_end   = {2'd0, eff_delay} + {5'd0, cfg.pulse_ticks};
    grid       = 1'b0;
    fire       = 1'b0;
    delay_d    = delay_q;
    digit_d    = digit_q;
    phase_d    = 9'd0;
    if (!armed_d) begin
      digit_d = LetterL;
    end else begin
      if (phase_zero) begin
        delay_d = calc_delay;
        digit_d = calc_digit;
      end
      grid = (phase_q < {1'b0, cfg.half_period_ticks});
      fire = grid && ({1'b0, phase_q} >= {2'd0, eff_delay}) &&
             ({1'b0, phase_q} < fire_end);
      if (phase_inc >= {1'b0, cfg.half_period_ticks, 1'b0}) begin
        phase_d = 9'd0;
      end else begin
        phase_d = phase_inc[8:0];
      end
    end
    out_d.grid_level = grid;
    out_d.fire_pulse = fire;
    out_d.segments   = SegTable[digit_d];
    out_d.armed_flag = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      armed_q       <= 1'b0;
      since_q       <= 10'd0;
      phase_q       <= 9'd0;
      delay_q       <= 8'd0;
      digit_q       <= LetterL;
    end else begin
      stage_valid_q <= accept || (stage_valid_q && !step);
      out_valid_q   <= step || (out_valid_q && out_stall_i);
      if (step) begin
        armed_q <= armed_d;
        since_q <= since_d;
        phase_q <= phase_d;
        delay_q <= delay_d;
        digit_q <= digit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  a_locked_phase_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !armed_q |-> phase_q == 9'd0
  ) else $error("phase counter runs while locked");

  a_locked_outputs: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.armed_flag) |->
      (!out_q.grid_level && !out_q.fire_pulse && out_q.segments == SegTable[LetterL])
  ) else $error("locked result shows activity");

  a_fire_in_first_half: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fire_pulse) |-> out_q.grid_level
  ) else $error("firing pulse outside the first half");

  a_toggle_at_boundary: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (armed_q != $past(armed_q)) |-> ($past(phase_q) == 9'd0 && since_q == 10'd0)
  ) else $error("arm flag toggled away from a cycle boundary");

endmodule

// ===== hdl/pafc_regs.sv =====
// APB configuration registers: debounce, half period and pulse width.
module pafc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pafc_pkg::PAddrW-1:0]  paddr,
  input  logic [pafc_pkg::PDataW-1:0]  pwdata,
  output logic [pafc_pkg::PDataW-1:0]  prdata,
  output logic                         pready,
  output pafc_pkg::cfg_t               cfg_o
);
  import pafc_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks    <= DebounceReset;
      cfg_q.half_period_ticks <= HalfPeriodReset;
      cfg_q.pulse_ticks       <= PulseReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDebounce:   cfg_q.debounce_ticks    <= pwdata[9:0];
        RegHalfPeriod: cfg_q.half_period_ticks <= pwdata[7:0];
        RegPulse:      cfg_q.pulse_ticks       <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegDebounce:   prdata = {22'd0, cfg_q.debounce_ticks};
      RegHalfPeriod: prdata = {24'd0, cfg_q.half_period_ticks};
      RegPulse:      prdata = {27'd0, cfg_q.pulse_ticks};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hdl/pafc_calc.sv =====
// Firing delay scaling and display digit derived from one potentiometer sample.
module pafc_calc (
  input  logic [11:0] sample_i,
  input  logic [7:0]  half_i,
  input  logic [4:0]  width_i,
  output logic [7:0]  delay_o,
  output logic [3:0]  digit_o
);
  import pafc_pkg::*;

  logic [19:0] prod;
  logic [20:0] quo_sum;
  logic [7:0]  quo;
  logic [7:0]  width_ext;
  logic [7:0]  limit;

  // Division by 4095: q = (x + (x >> 12) + 1) >> 12 is exact for this range.
  assign prod      = {8'd0, sample_i} * {12'd0, half_i};
  assign quo_sum   = {1'b0, prod} + {13'd0, prod[19:12]} + 21'd1;
  assign quo       = quo_sum[19:12];
  assign width_ext = {3'd0, width_i};
  assign limit     = (width_ext >= half_i) ? 8'd0 : half_i - width_ext;
  assign delay_o   = (quo > limit) ? limit : quo;

  always_comb begin
    digit_o = 4'd0;
    for (int k = 1; k <= DigitCount; k++) begin
      if (sample_i >= 12'(DigitStep * k)) begin
        digit_o = 4'(k);
      end
    end
  end

endmodule
